// ===== src/bfr_pkg.sv =====
`default_nettype none

package bfr_pkg;

  // Frame geometry: header, fourteen data bytes, CRC low, CRC high, tail.
  localparam int FRAME_LEN = 18;
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam int CRC_LAST  = FRAME_LEN - 4;  // last byte covered by the CRC
  localparam int CRC_LO    = FRAME_LEN - 3;
  localparam int CRC_HI    = FRAME_LEN - 2;
  localparam int LAST_IDX  = FRAME_LEN - 1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] HEADER_RESET = 8'h55;
  localparam logic [7:0] TAIL_RESET   = 8'h00;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 8'd1;

  localparam logic [1:0] STATUS_GOOD = 2'd0;
  localparam logic [1:0] STATUS_TAIL = 2'd1;
  localparam logic [1:0] STATUS_CRC  = 2'd2;

  localparam int DATA_W = 112;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        voltage;
    logic signed [15:0] current;
    logic [15:0]        quantity;
    logic [15:0]        capacity;
    logic [7:0]         charge_percent;
    logic [7:0]         control_byte;
    logic [15:0]        protection_flags;
    logic [15:0]        cycle_count;
  } bfr_result_t;

endpackage

`default_nettype wire

// ===== src/bfr_crc.sv =====
`default_nettype none

// Modbus CRC-16 update for one byte, LSB first, as eight unrolled shift steps.
module bfr_crc (
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data,
  output logic      [15:0] crc_out
);
  import bfr_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

// ===== src/bfr_frame.sv =====
`default_nettype none

// Frame tracker: header hunt, byte position, running CRC, byte store and checks.
module bfr_frame (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 take,
  input  wire logic [7:0]           data,
  input  wire logic [7:0]           header_byte,
  input  wire logic [7:0]           tail_byte,
  output logic                      result_valid,
  output bfr_pkg::bfr_result_t      result
);
  import bfr_pkg::*;

  logic             hunting;
  logic [IDX_W-1:0] byte_index;
  logic [15:0]      crc_reg;
  logic [15:0]      crc_in;
  logic [15:0]      crc_upd;
  logic             at_end;
  logic [7:0]       store [1:CRC_HI];

  assign crc_in = hunting ? CRC_INIT : crc_reg;

  bfr_crc u_crc (
    .crc_in  (crc_in),
    .data    (data),
    .crc_out (crc_upd)
  );

  assign at_end       = !hunting && (byte_index == IDX_W'(LAST_IDX));
  assign result_valid = take && at_end;

  always_comb begin
    result = '0;
    if (data != tail_byte) begin
      result.status = STATUS_TAIL;
    end else if (store[CRC_LO] != crc_reg[7:0] || store[CRC_HI] != crc_reg[15:8]) begin
      result.status = STATUS_CRC;
    end else begin
      result.status           = STATUS_GOOD;
      result.voltage          = {store[1], store[2]};
      result.current          = {store[3], store[4]};
      result.quantity         = {store[5], store[6]};
      result.capacity         = {store[7], store[8]};
      result.charge_percent   = store[9];
      result.control_byte     = store[10];
      result.protection_flags = {store[11], store[12]};
      result.cycle_count      = {store[13], store[14]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunting    <= 1'b1;
      byte_index <= '0;
      crc_reg    <= CRC_INIT;
    end else if (take) begin
      if (hunting) begin
        if (data == header_byte) begin
          hunting    <= 1'b0;
          byte_index <= IDX_W'(1);
          crc_reg    <= crc_upd;
        end
      end else if (byte_index >= IDX_W'(LAST_IDX)) begin
        // End of frame, or an impossible position: go back to hunting.
        hunting    <= 1'b1;
        byte_index <= '0;
        crc_reg    <= CRC_INIT;
      end else begin
        byte_index <= byte_index + IDX_W'(1);
        if (byte_index <= IDX_W'(CRC_LAST)) begin
          crc_reg <= crc_upd;
        end
      end
    end
  end

  // Each stored byte has its own fixed position and load enable.
  for (genvar i = 1; i <= CRC_HI; i++) begin : g_store
    always_ff @(posedge clk) begin
      if (take && !hunting && byte_index == IDX_W'(i)) begin
        store[i] <= data;
      end
    end
  end

  a_hunt_idx: assert property (@(posedge clk) disable iff (rst)
    hunting |-> byte_index == '0)
    else $error("byte position not cleared while hunting");

  a_res_frame: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !hunting && byte_index == IDX_W'(LAST_IDX))
    else $error("result outside the last frame position");

  a_end_hunt: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> hunting && crc_reg == CRC_INIT)
    else $error("hunting not resumed after frame end");

endmodule

`default_nettype wire

// ===== src/battery_frame_receiver.sv =====
// Battery frame receiver.
// Serial bytes arrive one per transfer on the s_axis channel. While hunting,
// bytes other than the header value are dropped; a header byte opens an
// 18-byte frame. Bytes 0 to 14 run through a Modbus CRC-16, bytes 15 and 16
// must hold that CRC low byte first, and byte 17 must equal the tail value.
// At the last byte one result transfer leaves on m_axis: tuser carries the
// status (good, tail wrong, CRC mismatch) and tdata the big-endian fields,
// all zero for a failed frame. Hunting then resumes.
// The cfg channel writes the header value (index 0) and tail value (index 1);
// the user must write them only while the block is idle, which the block
// itself does not enforce. Other indexes are ignored. cfg_ready is always high.
// Throughput is one byte per cycle unless a stalled result holds the input:
// the CRC update is an unrolled byte-wide XOR network between the input
// register and the state registers. The last frame byte passes the input
// register, then the frame checks, and its result is registered on m_axis.
// Reset clears both channels, restores the default header (0x55) and tail
// (0x00), and starts hunting. When the result receiver stalls, the held
// result stays put, one more byte can still be taken into the input register,
// and further bytes wait until the result has been transferred.
`default_nettype none

module battery_frame_receiver (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Input byte stream. tdata: rx_byte[7:0].
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,
  // Result stream. tdata: voltage[15:0], current[31:16], quantity[47:32],
  // capacity[63:48], charge_percent[71:64], control_byte[79:72],
  // protection_flags[95:80], cycle_count[111:96].
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [bfr_pkg::DATA_W-1:0]         m_axis_tdata,
  // tuser: status[1:0].
  output logic [1:0]                         m_axis_tuser,
  // Register write channel.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data
);
  import bfr_pkg::*;

  logic [7:0]  header_reg;
  logic [7:0]  tail_reg;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        take;
  logic        result_valid;
  bfr_result_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_reg <= HEADER_RESET;
      tail_reg   <= TAIL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HEADER: header_reg <= cfg_data;
        REG_TAIL:   tail_reg   <= cfg_data;
        default: ;
      endcase
    end
  end

  // The input register drains whenever the output register can take a result.
  assign take          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  bfr_frame u_frame (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .data         (in_byte),
    .header_byte  (header_reg),
    .tail_byte    (tail_reg),
    .result_valid (result_valid),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (result_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid) begin
      m_axis_tuser <= result.status;
      m_axis_tdata <= {result.cycle_count, result.protection_flags,
                       result.control_byte, result.charge_percent,
                       result.capacity, result.quantity,
                       result.current, result.voltage};
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != STATUS_GOOD) |-> m_axis_tdata == '0)
    else $error("failed frame carries nonzero data");

  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(in_valid))
    else $error("result appeared without a byte in the input register");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed before its transfer");

endmodule

`default_nettype wire

// ===== dv/tb_battery_frame_receiver.sv =====
module tb_battery_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  import bfr_pkg::*;

  // The watchdog is far above the slowest legal run, even with heavy
  // idling and the long result stall.
  localparam int RUN_LIMIT_NS     = 400_000;
  // A result leaves through the output register after the last frame byte;
  // the input register can also hold one byte, and this wait lets both drain.
  localparam int DRAIN_CYCLES     = 8;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PHASE_BYTES      = 500;
  localparam int BODY_LEN         = CRC_LAST;  // frame bytes 1 to 14
  localparam logic [CFG_IDX_W-1:0] NO_SUCH_REG = 8'hFF;

  typedef enum {FRAME_GOOD, FRAME_BAD_TAIL, FRAME_BAD_CRC, FRAME_BAD_BOTH} frame_flaw_t;

  // Every input of the block has a known value from time zero on.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'h00;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [DATA_W-1:0]     m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [7:0]            cfg_data = 8'h00;

  battery_frame_receiver u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // Receiver state as the testbench sees it. The register copies follow
  // every accepted register write; the frame state follows every accepted
  // byte transfer.
  logic [7:0]      header_setting = HEADER_RESET;
  logic [7:0]      tail_setting   = TAIL_RESET;
  logic            rx_hunting = 1'b1;
  logic [4:0]      rx_index   = '0;
  logic [15:0]     rx_crc     = CRC_INIT;
  logic [7:0]      rx_frame [FRAME_LEN];

  // Bytes still to be offered, and decoded frames still to be seen leaving.
  logic [7:0]      bytes_to_send [$];
  bfr_result_t     frames_due [$];
  logic [7:0]      body_bytes [BODY_LEN];

  int              fault_count = 0;
  int              phase_no = 0;
  int              send_idle_pct = 16;
  int              recv_idle_pct = 54;
  logic            long_hold = 1'b0;

  // Adds one byte at the end of the send queue.
  function automatic void append_byte(logic [7:0] b);
    bytes_to_send = {bytes_to_send, b};
  endfunction

  // One byte of the Modbus CRC-16, reflected, least significant bit first.
  function automatic logic [15:0] modbus_crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Advances the frame state by one received byte. When the byte closes a
  // frame, the decoded frame is queued for comparison.
  function automatic void decode_rx_byte(logic [7:0] b);
    bfr_result_t r;
    if (rx_hunting) begin
      if (b == header_setting) begin
        rx_frame[0] = b;
        rx_crc      = modbus_crc_step(CRC_INIT, b);
        rx_index    = 5'd1;
        rx_hunting  = 1'b0;
      end
      return;
    end
    if (rx_index >= FRAME_LEN) begin
      rx_hunting = 1'b1;
      rx_index   = '0;
      rx_crc     = CRC_INIT;
      return;
    end
    rx_frame[rx_index] = b;
    if (rx_index <= CRC_LAST) rx_crc = modbus_crc_step(rx_crc, b);
    if (rx_index < LAST_IDX) begin
      rx_index = rx_index + 5'd1;
      return;
    end
    // Last byte: the tail check takes precedence over the CRC check, and a
    // failed frame carries all-zero data fields.
    r = '0;
    if (rx_frame[LAST_IDX] != tail_setting) begin
      r.status = STATUS_TAIL;
    end else if ({rx_frame[CRC_HI], rx_frame[CRC_LO]} != rx_crc) begin
      r.status = STATUS_CRC;
    end else begin
      r.status           = STATUS_GOOD;
      r.voltage          = {rx_frame[1], rx_frame[2]};
      r.current          = {rx_frame[3], rx_frame[4]};
      r.quantity         = {rx_frame[5], rx_frame[6]};
      r.capacity         = {rx_frame[7], rx_frame[8]};
      r.charge_percent   = rx_frame[9];
      r.control_byte     = rx_frame[10];
      r.protection_flags = {rx_frame[11], rx_frame[12]};
      r.cycle_count      = {rx_frame[13], rx_frame[14]};
    end
    frames_due = {frames_due, r};
    rx_hunting = 1'b1;
    rx_index   = '0;
    rx_crc     = CRC_INIT;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    fault_count++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %h, should be %h", name, got, want));
    end
  endtask

  // Queues one frame built around body_bytes, with the chosen defect.
  task automatic queue_frame(frame_flaw_t flaw, logic [7:0] hdr, logic [7:0] tl);
    logic [15:0] crc;
    logic [15:0] crc_flip;
    logic [7:0]  tail_flip;
    crc       = modbus_crc_step(CRC_INIT, hdr);
    crc_flip  = '0;
    tail_flip = '0;
    append_byte(hdr);
    for (int i = 0; i < BODY_LEN; i++) begin
      append_byte(body_bytes[i]);
      crc = modbus_crc_step(crc, body_bytes[i]);
    end
    if (flaw == FRAME_BAD_CRC || flaw == FRAME_BAD_BOTH) begin
      crc_flip = 16'($urandom_range(1, 65535));
    end
    if (flaw == FRAME_BAD_TAIL || flaw == FRAME_BAD_BOTH) begin
      tail_flip = 8'($urandom_range(1, 255));
    end
    crc = crc ^ crc_flip;
    append_byte(crc[7:0]);
    append_byte(crc[15:8]);
    append_byte(tl ^ tail_flip);
  endtask

  // Any byte value except the one that would open a frame.
  function automatic logic [7:0] line_noise(logic [7:0] hdr);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == hdr) ? ~b : b;
  endfunction

  // Mostly well-formed frames with random content, some of them damaged.
  // The rest is cut-off frames, which swallow part of what follows, and raw
  // noise that may hold a stray header value. Only frame bytes count toward
  // the budget.
  task automatic queue_random_traffic(int budget, logic [7:0] hdr, logic [7:0] tl);
    int          queued;
    int          pick;
    int          cut_len;
    frame_flaw_t flaw;
    queued = 0;
    while (queued < budget) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        repeat ($urandom_range(0, 2)) append_byte(line_noise(hdr));
        foreach (body_bytes[i]) body_bytes[i] = 8'($urandom_range(0, 255));
        pick = $urandom_range(99);
        if (pick < 70)      flaw = FRAME_GOOD;
        else if (pick < 80) flaw = FRAME_BAD_TAIL;
        else if (pick < 90) flaw = FRAME_BAD_CRC;
        else                flaw = FRAME_BAD_BOTH;
        queue_frame(flaw, hdr, tl);
        queued += FRAME_LEN;
      end else if (pick < 88) begin
        cut_len = $urandom_range(1, FRAME_LEN - 2);
        append_byte(hdr);
        repeat (cut_len) append_byte(8'($urandom_range(0, 255)));
        queued += cut_len + 1;
      end else begin
        repeat ($urandom_range(1, 6)) append_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Waits for every byte to be taken and every frame to come out, then
  // lets the pipeline run dry before anything else happens. The check runs
  // on the falling edge, where the clocked processes have settled.
  task automatic drain_to_idle();
    do @(negedge clk);
    while (bytes_to_send.size() != 0 || s_axis_tvalid || frames_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One write on the register channel. Valid stays up so that writes can
  // follow back to back; the caller lowers it after the last one.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == REG_HEADER)    header_setting = val;
    else if (idx == REG_TAIL) tail_setting   = val;
  endtask

  // Writes both registers, then two indexes that do not exist and must
  // leave the settings alone.
  task automatic program_regs(logic [7:0] hdr, logic [7:0] tl);
    write_reg(REG_HEADER, hdr);
    write_reg(REG_TAIL, tl);
    write_reg(NO_SUCH_REG, 8'($urandom_range(0, 255)));
    write_reg(CFG_IDX_W'($urandom_range(REG_TAIL + 1, NO_SUCH_REG - 1)),
              8'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
  endtask

  // Byte sender. The predictor is advanced at the edge where a transfer
  // happens, using the byte that was on the bus at that edge. A new byte is
  // offered only when the slot is free, so valid is never dropped and
  // raised again within one edge.
  always @(posedge clk) begin : byte_driver
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_rx_byte(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata  <= bytes_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver readiness: random stalls, plus the long hold below.
  always @(posedge clk) begin : result_sink
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !long_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // In the second phase the receiver refuses results for a long stretch
  // while bytes keep coming, so a finished frame backs up and the block
  // has to stop taking input.
  initial begin : long_hold_proc
    wait (phase_no == 1);
    repeat (50) @(posedge clk);
    long_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Every result transfer is unpacked and compared field by field with
  // the oldest decoded frame still waiting.
  always @(posedge clk) begin : result_monitor
    bfr_result_t seen;
    bfr_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.status           = m_axis_tuser;
      seen.voltage          = m_axis_tdata[15:0];
      seen.current          = m_axis_tdata[31:16];
      seen.quantity         = m_axis_tdata[47:32];
      seen.capacity         = m_axis_tdata[63:48];
      seen.charge_percent   = m_axis_tdata[71:64];
      seen.control_byte     = m_axis_tdata[79:72];
      seen.protection_flags = m_axis_tdata[95:80];
      seen.cycle_count      = m_axis_tdata[111:96];
      if (frames_due.size() == 0) begin
        report_mismatch($sformatf("result with status %0d but no frame pending",
                                  seen.status));
      end else begin
        want = frames_due.pop_front();
        compare_field("status", 16'(seen.status), 16'(want.status));
        compare_field("voltage", seen.voltage, want.voltage);
        compare_field("current", seen.current, want.current);
        compare_field("quantity", seen.quantity, want.quantity);
        compare_field("capacity", seen.capacity, want.capacity);
        compare_field("charge_percent", 16'(seen.charge_percent),
                      16'(want.charge_percent));
        compare_field("control_byte", 16'(seen.control_byte),
                      16'(want.control_byte));
        compare_field("protection_flags", seen.protection_flags, want.protection_flags);
        compare_field("cycle_count", seen.cycle_count, want.cycle_count);
      end
    end
  end

  // Stimulus. Items and idling settings are loaded on the falling edge so
  // that the clocked processes never race with them.
  initial begin : stimulus
    logic [7:0] hdr;
    logic [7:0] tl;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings. Two noise bytes are dropped while hunting. The first
    // frame carries field extremes and the header value as plain data; the
    // second has the opposite extremes; the third has a bad tail and a bad
    // CRC at once, where the tail check must win.
    @(negedge clk);
    append_byte(8'h00);
    append_byte(8'hAA);
    body_bytes = '{8'hFF, 8'hFF, 8'h80, 8'h00, 8'h55, 8'h55, 8'h00,
                   8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00};
    queue_frame(FRAME_GOOD, HEADER_RESET, TAIL_RESET);
    body_bytes = '{8'h00, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'h00, 8'hFF,
                   8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF};
    queue_frame(FRAME_GOOD, HEADER_RESET, TAIL_RESET);
    queue_frame(FRAME_BAD_BOTH, HEADER_RESET, TAIL_RESET);
    queue_random_traffic(PHASE_BYTES - 3 * FRAME_LEN, HEADER_RESET, TAIL_RESET);
    drain_to_idle();

    // Lowest header with highest tail; the long result stall happens here.
    program_regs(8'h00, 8'hFF);
    @(negedge clk);
    phase_no = 1;
    queue_random_traffic(PHASE_BYTES, header_setting, tail_setting);
    drain_to_idle();

    // Highest header with lowest tail; the sender now idles more often.
    program_regs(8'hFF, 8'h00);
    @(negedge clk);
    phase_no      = 2;
    send_idle_pct = 54;
    recv_idle_pct = 16;
    queue_random_traffic(PHASE_BYTES, header_setting, tail_setting);
    drain_to_idle();

    // Random settings, sometimes with header and tail equal; no idling.
    hdr = 8'($urandom_range(0, 255));
    tl  = $urandom_range(1) ? hdr : 8'($urandom_range(0, 255));
    program_regs(hdr, tl);
    @(negedge clk);
    phase_no      = 3;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_traffic(PHASE_BYTES, header_setting, tail_setting);
    drain_to_idle();

    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
